// File: rtl/stq_pkg.sv
// Package with the types, constants and helpers of the sorted timer queue.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    localparam int ID_W           = 4;
    localparam int TIME_W         = 32;
    localparam int FUNC_W         = 2;
    localparam int IN_DATA_W      = 104;
    localparam int OUT_DATA_W     = 40;
    localparam int TIMER_COUNT_DEF = 16;
    localparam int MAX_EXPIRIES   = 16;
    localparam int COUNT_W        = $clog2(MAX_EXPIRIES + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_CHECK,
        ST_REARM
    } state_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } cell_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } slot_t;

    // True when time a is not later than time b under wrapping comparison.
    function automatic logic not_later(input logic [TIME_W-1:0] a,
                                       input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return (d == '0) || d[TIME_W-1];
    endfunction

endpackage

`default_nettype wire

// File: rtl/stq_cell.sv
// One list cell of the sorted timer queue: holds one slot and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module stq_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stq_pkg::cell_cmd_t cmd,
    input  wire stq_pkg::slot_t    prev_slot,
    input  wire stq_pkg::slot_t    next_slot,
    input  wire logic              before_in,
    output logic                   before_out,
    input  wire logic              gone_in,
    output logic                   gone_out,
    output stq_pkg::slot_t         slot
);
    import stq_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [TIME_W-1:0] expiry_reg;
    logic [TIME_W-1:0] expiry_next;
    logic              hit;
    logic              match;

    assign hit        = !valid_reg || not_later(cmd.expiry, expiry_reg);
    assign match      = valid_reg && (id_reg == cmd.id);
    assign before_out = before_in || hit;
    assign gone_out   = gone_in || match;
    assign slot       = '{valid: valid_reg, id: id_reg, expiry: expiry_reg};

    always_comb
    begin
        valid_next  = valid_reg;
        id_next     = id_reg;
        expiry_next = expiry_reg;
        unique case (cmd.op)
            OP_INSERT:
            begin
                if (before_in)
                begin
                    valid_next  = prev_slot.valid;
                    id_next     = prev_slot.id;
                    expiry_next = prev_slot.expiry;
                end
                else if (hit)
                begin
                    valid_next  = 1'b1;
                    id_next     = cmd.id;
                    expiry_next = cmd.expiry;
                end
            end
            OP_REMOVE:
            begin
                if (gone_out)
                begin
                    valid_next  = next_slot.valid;
                    id_next     = next_slot.id;
                    expiry_next = next_slot.expiry;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        expiry_reg <= expiry_next;
    end

endmodule

`default_nettype wire

// File: rtl/sorted_software_timer_queue_unit.sv
// Top level of the sorted timer queue: command sequencer, timer tables and the cell chain.
//
//  Channel   Direction  Signals                          Contents
//  s_*       in         s_tvalid s_tready s_tdata s_tuser  one request: tick, start or stop
//  m_*       out        m_tvalid m_tready m_tdata m_tlast  one expiry, tlast on the final one
//
// A stop request is accepted and then makes the removal pass through the cell chain; a
// start request makes the insertion pass as well, after the removal pass.
// A tick is accepted, then ST_CHECK removes each due head cell and reads the timer tables,
// and ST_REARM takes the tag and, for a periodic timer, runs the re-arm pass.
// Reset clears the slot valid bits, the time and the sequencer; no clearing pass is run.
// A full output register stalls the expiry sequence; new requests wait until it is done.
`timescale 1ns / 1ps
`default_nettype none

module sorted_software_timer_queue_unit #(
    parameter int TIMER_COUNT = stq_pkg::TIMER_COUNT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // timer_id [3:0], delay_ticks [35:4], restart_ticks [67:36], tag [99:68], zero fill
    input  wire logic [stq_pkg::IN_DATA_W-1:0]   s_tdata,
    // func [1:0]
    input  wire logic [stq_pkg::FUNC_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // expired_id [3:0], expired_tag [35:4], zero fill
    output logic [stq_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast
);
    import stq_pkg::*;

    localparam int IDX_W = $clog2(TIMER_COUNT);

    state_t            state_reg;
    state_t            state_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [TIME_W-1:0] ins_exp_reg;
    logic [TIME_W-1:0] ins_exp_next;
    logic              start_reg;
    logic              start_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [ID_W-1:0]   pend_id_reg;
    logic [ID_W-1:0]   pend_id_next;
    logic [TIME_W-1:0] pend_tag_reg;
    logic [TIME_W-1:0] pend_tag_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [ID_W-1:0]   out_id_next;
    logic [TIME_W-1:0] out_tag_reg;
    logic [TIME_W-1:0] out_tag_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic [TIME_W-1:0] period_mem [TIMER_COUNT];
    logic [TIME_W-1:0] tag_mem    [TIMER_COUNT];
    logic              table_wr;
    logic [TIME_W-1:0] rd_period_reg;
    logic [TIME_W-1:0] rd_tag_reg;

    logic [ID_W-1:0]   in_id;
    logic [TIME_W-1:0] in_delay;
    logic [TIME_W-1:0] in_period;
    logic [TIME_W-1:0] in_tag;
    logic              in_id_ok;

    cell_cmd_t         cmd;
    slot_t             slots [TIMER_COUNT];
    logic [TIMER_COUNT:0] before_chain;
    logic [TIMER_COUNT:0] gone_chain;
    slot_t             head;
    logic [IDX_W-1:0]  head_idx;
    logic [TIME_W-1:0] head_diff;
    logic              head_due;
    logic              full;
    logic              out_free;

    assign in_id     = s_tdata[3:0];
    assign in_delay  = s_tdata[35:4];
    assign in_period = s_tdata[67:36];
    assign in_tag    = s_tdata[99:68];
    assign in_id_ok  = 32'(in_id) < 32'(TIMER_COUNT);

    assign head        = slots[0];
    assign head_idx    = IDX_W'(head.id);
    assign head_diff   = time_reg - head.expiry;
    assign head_due    = head.valid && !head_diff[TIME_W-1] &&
                         (count_reg < COUNT_W'(MAX_EXPIRIES));
    assign full        = slots[TIMER_COUNT-1].valid;
    assign out_free    = !out_valid_reg || m_tready;

    assign before_chain[0] = 1'b0;
    assign gone_chain[0]   = 1'b0;

    for (genvar i = 0; i < TIMER_COUNT; i++)
    begin : g_cell
        slot_t prev_slot;
        slot_t next_slot;
        if (i == 0)
        begin : g_first
            assign prev_slot = '0;
        end
        else
        begin : g_prev
            assign prev_slot = slots[i-1];
        end
        if (i == TIMER_COUNT - 1)
        begin : g_last
            assign next_slot = '0;
        end
        else
        begin : g_next
            assign next_slot = slots[i+1];
        end
        stq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_slot  (prev_slot),
            .next_slot  (next_slot),
            .before_in  (before_chain[i]),
            .before_out (before_chain[i+1]),
            .gone_in    (gone_chain[i]),
            .gone_out   (gone_chain[i+1]),
            .slot       (slots[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        time_next       = time_reg;
        id_next         = id_reg;
        ins_exp_next    = ins_exp_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_tag_next   = pend_tag_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_id_next     = out_id_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        table_wr        = 1'b0;
        s_tready        = 1'b0;
        cmd.op          = OP_NOP;
        cmd.id          = id_reg;
        cmd.expiry      = ins_exp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (func_t'(s_tuser))
                        FUNC_TICK:
                        begin
                            time_next  = time_reg + 1'b1;
                            count_next = '0;
                            state_next = ST_CHECK;
                        end
                        FUNC_START:
                        begin
                            if (in_id_ok)
                            begin
                                table_wr     = 1'b1;
                                id_next      = in_id;
                                ins_exp_next = time_reg + in_delay;
                                start_next   = 1'b1;
                                state_next   = ST_REMOVE;
                            end
                        end
                        FUNC_STOP:
                        begin
                            if (in_id_ok)
                            begin
                                id_next    = in_id;
                                start_next = 1'b0;
                                state_next = ST_REMOVE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_REMOVE:
            begin
                cmd.op     = OP_REMOVE;
                state_next = start_reg ? ST_INSERT : ST_IDLE;
            end
            ST_INSERT:
            begin
                cmd.op     = full ? OP_NOP : OP_INSERT;
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                if (head_due)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_id_next    = pend_id_reg;
                            out_tag_next   = pend_tag_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = head.id;
                        count_next      = count_reg + 1'b1;
                        cmd.op          = OP_REMOVE;
                        cmd.id          = head.id;
                        id_next         = head.id;
                        state_next      = ST_REARM;
                    end
                end
                else if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_id_next     = pend_id_reg;
                        out_tag_next    = pend_tag_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REARM:
            begin
                pend_tag_next = rd_tag_reg;
                if (rd_period_reg != '0)
                begin
                    cmd.op     = full ? OP_NOP : OP_INSERT;
                    cmd.expiry = time_reg + rd_period_reg;
                end
                state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            time_reg       <= '0;
            start_reg      <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            start_reg      <= start_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        ins_exp_reg  <= ins_exp_next;
        pend_id_reg  <= pend_id_next;
        pend_tag_reg <= pend_tag_next;
        out_id_reg   <= out_id_next;
        out_tag_reg  <= out_tag_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (table_wr)
        begin
            period_mem[IDX_W'(in_id)] <= in_period;
            tag_mem[IDX_W'(in_id)]    <= in_tag;
        end
        rd_period_reg <= period_mem[head_idx];
        rd_tag_reg    <= tag_mem[head_idx];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_tag_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: bench/timer_expiry_monitor.sv
// Monitor that predicts timer expiries from accepted requests and checks every result.
`timescale 1ns / 1ps

module timer_expiry_monitor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [stq_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [stq_pkg::FUNC_W-1:0]     s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [stq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                           m_tlast,
    output int                                  errors,
    output int                                  pending
);
    import stq_pkg::*;

    localparam int TIMERS = TIMER_COUNT_DEF;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tag;
        logic              last;
    } expiry_t;

    expiry_t           expiries_due[$];
    logic [TIME_W-1:0] now_ticks;
    logic [ID_W-1:0]   list_id [TIMERS];
    logic [TIME_W-1:0] list_at [TIMERS];
    int                list_len;
    logic [TIME_W-1:0] period_of [TIMERS];
    logic [TIME_W-1:0] tag_of [TIMERS];

    function automatic int find_timer(input logic [ID_W-1:0] id);
        for (int i = 0; i < list_len; i++)
        begin
            if (list_id[i] == id)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic drop_entry(input int pos);
        for (int i = pos; i + 1 < list_len; i++)
        begin
            list_id[i] = list_id[i + 1];
            list_at[i] = list_at[i + 1];
        end
        list_len--;
    endtask

    // A new entry goes ahead of every entry whose expiry is not earlier than its own.
    task automatic place_entry(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] at);
        int                       p;
        logic signed [TIME_W-1:0] lead;
        if (list_len >= TIMERS)
        begin
            return;
        end
        p = 0;
        while (p < list_len)
        begin
            lead = at - list_at[p];
            if (lead <= 0)
            begin
                break;
            end
            p++;
        end
        for (int i = list_len; i > p; i--)
        begin
            list_id[i] = list_id[i - 1];
            list_at[i] = list_at[i - 1];
        end
        list_id[p] = id;
        list_at[p] = at;
        list_len++;
    endtask

    task automatic advance_time();
        expiry_t                  e;
        logic [ID_W-1:0]          t;
        logic signed [TIME_W-1:0] overdue;
        int                       k;
        now_ticks = now_ticks + 1'b1;
        k = 0;
        while (k < MAX_EXPIRIES && list_len > 0)
        begin
            overdue = now_ticks - list_at[0];
            if (overdue < 0)
            begin
                break;
            end
            t = list_id[0];
            expiries_due.push_back('{id: t, tag: tag_of[t], last: 1'b0});
            drop_entry(0);
            if (period_of[t] != '0)
            begin
                place_entry(t, now_ticks + period_of[t]);
            end
            k++;
        end
        if (k > 0)
        begin
            e = expiries_due.pop_back();
            e.last = 1'b1;
            expiries_due.push_back(e);
        end
    endtask

    task automatic take_request(input logic [FUNC_W-1:0] code, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] period,
                                input logic [TIME_W-1:0] tag);
        int pos;
        case (code)
            FUNC_TICK:
            begin
                advance_time();
            end
            FUNC_START:
            begin
                pos = find_timer(id);
                if (pos >= 0)
                begin
                    drop_entry(pos);
                end
                period_of[id] = period;
                tag_of[id] = tag;
                place_entry(id, now_ticks + delay);
            end
            FUNC_STOP:
            begin
                pos = find_timer(id);
                if (pos >= 0)
                begin
                    drop_entry(pos);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_expiry();
        expiry_t e;
        if (expiries_due.size() == 0)
        begin
            $error("expiry with nothing expected: expired_id %0d expired_tag %h last %b",
                   m_tdata[ID_W-1:0], m_tdata[ID_W +: TIME_W], m_tlast);
            errors++;
        end
        else
        begin
            e = expiries_due.pop_front();
            if (m_tdata[ID_W-1:0] !== e.id)
            begin
                $error("expired_id: expected %0d, actual %0d", e.id, m_tdata[ID_W-1:0]);
                errors++;
            end
            if (m_tdata[ID_W +: TIME_W] !== e.tag)
            begin
                $error("expired_tag: expected %h, actual %h", e.tag, m_tdata[ID_W +: TIME_W]);
                errors++;
            end
            if (m_tlast !== e.last)
            begin
                $error("last: expected %b, actual %b", e.last, m_tlast);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ticks = '0;
            list_len = 0;
            expiries_due.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            // Results leave only after their tick has been accepted, so they are checked first.
            if (m_tvalid && m_tready)
            begin
                check_expiry();
            end
            if (s_tvalid && s_tready)
            begin
                take_request(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W +: TIME_W],
                             s_tdata[ID_W + TIME_W +: TIME_W],
                             s_tdata[ID_W + 2 * TIME_W +: TIME_W]);
            end
            pending = expiries_due.size();
        end
    end

endmodule

// File: bench/sorted_software_timer_queue_unit_test.sv
// Top of the timer queue bench: clock, reset, request and result traffic, and the verdict.
`timescale 1ns / 1ps

module sorted_software_timer_queue_unit_test;

    import stq_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;
    localparam int ITEM_TARGET    = 320;
    localparam int STEADY_FROM    = 260;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    int                    errors;
    int                    pending;
    int                    items;
    bit                    steady;
    bit                    hold_results;

    sorted_software_timer_queue_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    timer_expiry_monitor monitor (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [TIME_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return $urandom();
        end
        if (r == 1)
        begin
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [TIME_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return '0;
        end
        if (r < 9)
        begin
            return $urandom_range(1, 8);
        end
        return $urandom();
    endfunction

    task automatic issue_request(input logic [FUNC_W-1:0] code, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] delay,
                                 input logic [TIME_W-1:0] period,
                                 input logic [TIME_W-1:0] tag);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = code;
        s_tdata = {4'b0, tag, period, delay, id};
        do
            @(posedge clk);
        while (!s_tready);
        items++;
    endtask

    task automatic tick_request();
        issue_request(FUNC_TICK, ID_W'($urandom()), $urandom(), $urandom(), $urandom());
    endtask

    task automatic start_timer(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] delay,
                               input logic [TIME_W-1:0] period, input logic [TIME_W-1:0] tag);
        issue_request(FUNC_START, id, delay, period, tag);
    endtask

    task automatic stop_timer(input logic [ID_W-1:0] id);
        issue_request(FUNC_STOP, id, $urandom(), $urandom(), $urandom());
    endtask

    task automatic sender_gap();
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 17)) @(negedge clk);
        end
    endtask

    task automatic drain_pause();
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending == 0);
    endtask

    // Every timer started at once; some periods are long enough to come due again at once.
    task automatic fill_table();
        for (int i = 0; i < TIMER_COUNT_DEF; i++)
        begin
            start_timer(ID_W'(i), $urandom_range(0, 2),
                        ($urandom_range(0, 3) == 0) ? 32'h8000_0000 + $urandom_range(1, 1000)
                                                    : $urandom_range(0, 4),
                        $urandom());
        end
        repeat (3) tick_request();
    endtask

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
                m_tready = 1'b1;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int pick;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_TICK;
        items = 0;
        steady = 1'b0;
        hold_results = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests: empty tick, due edges, restart, stops, ignored code, equal expiry.
        tick_request();
        start_timer(4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        start_timer(4'd15, 32'd1, 32'd3, 32'h0000_0000);
        start_timer(4'd5, 32'hFFFF_FFFF, 32'd0, 32'hA5A5_5A5A);
        start_timer(4'd7, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0123_4567);
        issue_request(FUNC_RESERVED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        stop_timer(4'd9);
        repeat (3) tick_request();
        start_timer(4'd15, 32'd2, 32'd0, 32'h5555_AAAA);
        stop_timer(4'd15);
        stop_timer(4'd7);
        start_timer(4'd3, 32'd2, 32'd0, 32'h3333_3333);
        start_timer(4'd4, 32'd2, 32'd0, 32'h4444_4444);
        repeat (3) tick_request();
        drain_pause();

        // Full table with periods that come due again inside the same tick.
        for (int i = 0; i < TIMER_COUNT_DEF; i++)
        begin
            start_timer(ID_W'(i), 32'd0, 32'hFFFF_FFF0, $urandom());
        end
        repeat (2) tick_request();
        for (int i = 0; i < TIMER_COUNT_DEF; i++)
        begin
            start_timer(ID_W'(i), 32'd0, 32'd0, $urandom());
        end
        repeat (2) tick_request();
        drain_pause();

        // Results held back while ticks keep coming, so the block has to stall requests.
        for (int i = 0; i < 4; i++)
        begin
            start_timer(ID_W'(i), 32'd0, 32'd1, $urandom());
        end
        hold_results = 1'b1;
        repeat (12) tick_request();
        for (int i = 0; i < 4; i++)
        begin
            stop_timer(ID_W'(i));
        end
        drain_pause();

        while (items < ITEM_TARGET)
        begin
            steady = (items >= STEADY_FROM);
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                start_timer(ID_W'($urandom()), pick_delay(), pick_period(), $urandom());
            end
            else if (pick < 75)
            begin
                tick_request();
            end
            else if (pick < 88)
            begin
                stop_timer(ID_W'($urandom()));
            end
            else if (pick < 92)
            begin
                issue_request(FUNC_RESERVED, ID_W'($urandom()), $urandom(), $urandom(),
                              $urandom());
            end
            else if (pick < 94 && !steady)
            begin
                fill_table();
            end
            else if (pick < 97 && !steady)
            begin
                drain_pause();
            end
            else
            begin
                tick_request();
            end
            sender_gap();
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sorted_software_timer_queue_unit.f
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_software_timer_queue_unit.sv
bench/timer_expiry_monitor.sv
bench/sorted_software_timer_queue_unit_test.sv
